FILE: design/dtmc_pkg.sv
// Shared constants, types and sine lookup for the dual-tone mains canceller.
package dtmc_pkg;

  localparam int NUM_CH      = 4;
  localparam int CH_W        = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int NUM_TERMS   = 4;
  localparam int TERM_W      = 2;
  localparam int WADDR_W     = CH_W + TERM_W;
  localparam int SUB_W       = 4;

  localparam int SAMPLE_W    = 16;
  localparam int OUT_W       = 18;
  localparam int CFG_W       = 16;
  localparam int REG_IDX_W   = 2;
  localparam int TRIG_W      = 16;
  localparam int WEIGHT_W    = 32;
  localparam int OPND_W      = 32;
  localparam int PROD_W      = 64;
  localparam int GAIN_W      = 17;

  localparam int PHASE_BITS  = 16;
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int HALF_DEPTH  = TABLE_DEPTH / 2;
  localparam int QTR_DEPTH   = TABLE_DEPTH / 4;
  localparam int MAG_W       = 15;

  localparam int LEAK_SHIFT  = 7;
  localparam int OUT_SHIFT   = 23;
  localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(65536);
  localparam logic signed [PROD_W-1:0] ROUND_Q23 = PROD_W'(64'd4194304);
  localparam logic signed [PROD_W-1:0] OUT_MAX   = PROD_W'(64'd131071);
  localparam logic signed [PROD_W-1:0] OUT_MIN   = -PROD_W'(64'd131072);

  localparam logic [CFG_W-1:0] LEAK_RESET   = CFG_W'(65208);
  localparam logic [CFG_W-1:0] STEP_A_RESET = CFG_W'(6715);
  localparam logic [CFG_W-1:0] STEP_B_RESET = CFG_W'(8058);

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LEAK   = 2'd0,
    REG_STEP_A = 2'd1,
    REG_STEP_B = 2'd2
  } dtmc_reg_e;

  typedef enum logic [1:0] {
    ACC_HOLD     = 2'd0,
    ACC_PROD     = 2'd1,
    ACC_PROD_SHL = 2'd2
  } acc_sel_e;

  typedef struct packed {
    logic     mul_en;
    acc_sel_e acc_sel;
  } mac_ctl_t;

  typedef logic [MAG_W-1:0] qsin_tab_t [QTR_DEPTH+1];

  // Unsigned Q0.15 sine magnitude of a first-quarter cycle fraction (32 bit), Taylor series in Q30
  function automatic logic [MAG_W-1:0] sine_mag(input logic [63:0] f);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    x    = (f * TWO_PI_Q30) >> 32;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    r = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return MAG_W'(r);
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t t;
    for (int k = 0; k <= QTR_DEPTH; k++) begin
      t[k] = sine_mag(64'(k) << (32 - IDX_W));
    end
    return t;
  endfunction

  localparam qsin_tab_t QSIN = build_qsin();

  // Signed Q1.15 sine at a full-circle index, by quarter-wave symmetry
  function automatic logic signed [TRIG_W-1:0] trig_val(input logic [IDX_W-1:0] idx);
    logic [IDX_W-2:0] r;
    logic [IDX_W-2:0] q;
    logic [MAG_W-1:0] m;
    r = idx[IDX_W-2:0];
    if (32'(r) > QTR_DEPTH) begin
      q = (IDX_W-1)'(HALF_DEPTH - int'(32'(r)));
    end else begin
      q = r;
    end
    m = QSIN[q];
    if (idx[IDX_W-1]) begin
      return -signed'(TRIG_W'(m));
    end
    return signed'(TRIG_W'(m));
  endfunction

  function automatic logic [IDX_W-1:0] phase_idx(input logic [PHASE_BITS-1:0] phase);
    return IDX_W'({phase, {IDX_W{1'b0}}} >> PHASE_BITS);
  endfunction

  function automatic logic [PHASE_BITS-1:0] scale_step(input logic [CFG_W-1:0] step);
    return PHASE_BITS'({step, {PHASE_BITS{1'b0}}} >> CFG_W);
  endfunction

endpackage

FILE: design/dtmc_mac.sv
// Shared 32x32 signed multiplier with product register and accumulator.
module dtmc_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dtmc_pkg::mac_ctl_t                  ctl_i,
  input  logic signed [dtmc_pkg::OPND_W-1:0]  op_a_i,
  input  logic signed [dtmc_pkg::OPND_W-1:0]  op_b_i,
  output logic signed [dtmc_pkg::PROD_W-1:0]  prod_o,
  output logic signed [dtmc_pkg::PROD_W-1:0]  sum_o
);
  import dtmc_pkg::*;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [PROD_W-1:0] acc_q, acc_d;

  always_comb begin
    prod_d = ctl_i.mul_en ? (op_a_i * op_b_i) : prod_q;
    acc_d  = acc_q;
    unique case (ctl_i.acc_sel)
      ACC_HOLD:     acc_d = acc_q;
      ACC_PROD:     acc_d = prod_q;
      ACC_PROD_SHL: acc_d = prod_q <<< LEAK_SHIFT;
      default:      acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
    end
  end

  assign prod_o = prod_q;
  assign sum_o  = acc_q + prod_q;

endmodule

FILE: design/dual_tone_mains_canceller.sv
// Top level of the dual-tone mains canceller.
// Takes one set of four 16-bit samples per item and returns the four channels with the
// stronger of two mains tones removed, saturated to 18 bits. An item goes through the
// sine/cosine lookup, then per channel through the single shared 32x32 multiplier (the
// four leaky weight updates, the two weight energies, the reconstruction), then waits
// until the previous result in the output register is taken, and is loaded into it.
// No new item is accepted before that load.
// The next item is accepted while a result waits there.
// Configuration writes take effect at once and must only come while the block is idle.
module dual_tone_mains_canceller (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [dtmc_pkg::REG_IDX_W-1:0]          cfg_idx_i,
  input  logic [dtmc_pkg::CFG_W-1:0]              cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [dtmc_pkg::SAMPLE_W-1:0]    sample_ch0_i,
  input  logic signed [dtmc_pkg::SAMPLE_W-1:0]    sample_ch1_i,
  input  logic signed [dtmc_pkg::SAMPLE_W-1:0]    sample_ch2_i,
  input  logic signed [dtmc_pkg::SAMPLE_W-1:0]    sample_ch3_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [dtmc_pkg::OUT_W-1:0]       clean_ch0_o,
  output logic signed [dtmc_pkg::OUT_W-1:0]       clean_ch1_o,
  output logic signed [dtmc_pkg::OUT_W-1:0]       clean_ch2_o,
  output logic signed [dtmc_pkg::OUT_W-1:0]       clean_ch3_o
);
  import dtmc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_TRIG = 6'b000010,
    ST_WUPD = 6'b000100,
    ST_ENRG = 6'b001000,
    ST_RECN = 6'b010000,
    ST_FIN  = 6'b100000
  } dtmc_state_e;

  dtmc_state_e             state_q, state_d;
  logic [SUB_W-1:0]        sub_q, sub_d;
  logic [CH_W-1:0]         ch_q, ch_d;
  logic [CFG_W-1:0]        leak_q, step_a_q, step_b_q;
  logic [PHASE_BITS-1:0]   phase_a_q, phase_b_q;
  logic                    out_valid_q, out_valid_d;

  logic signed [WEIGHT_W-1:0] weight_q [NUM_CH*NUM_TERMS];
  logic signed [SAMPLE_W-1:0] x_q      [NUM_CH];
  logic signed [TRIG_W-1:0]   trig_q   [NUM_TERMS];
  logic signed [OUT_W-1:0]    work_q   [NUM_CH];
  logic signed [OUT_W-1:0]    clean_q  [NUM_CH];
  logic [PROD_W-1:0]          ea_q;
  logic                       pick_a_q;

  logic                       in_acc;
  logic [TERM_W-1:0]          rd_j;
  logic [WADDR_W-1:0]         w_addr;
  logic signed [WEIGHT_W-1:0] w_rd;
  logic signed [WEIGHT_W-1:0] w_new;
  logic                       w_we;
  logic signed [TRIG_W-1:0]   trig_rd;
  logic signed [SAMPLE_W-1:0] x_cur;
  logic [GAIN_W-1:0]          gain;
  logic [IDX_W-1:0]           trig_idx;
  logic                       trig_we;
  logic                       phase_adv;
  logic                       ea_we;
  logic                       pick_we;
  logic                       work_we;
  logic                       out_load;
  logic signed [PROD_W-1:0]   y_full;
  logic signed [PROD_W-1:0]   y_shift;
  logic signed [OUT_W-1:0]    y_sat;

  mac_ctl_t                   mac_ctl;
  logic signed [OPND_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]   prod, sum;

  dtmc_mac u_dtmc_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod),
    .sum_o  (sum)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign x_cur      = x_q[ch_q];
  assign gain       = ONE_Q16 - GAIN_W'(leak_q);

  always_comb begin
    rd_j = '0;
    unique case (state_q)
      ST_WUPD: rd_j = sub_q[3:2];
      ST_ENRG: rd_j = TERM_W'(sub_q);
      ST_RECN: rd_j = {~pick_a_q, sub_q[0]};
      default: rd_j = '0;
    endcase
  end

  assign w_addr  = {ch_q, rd_j};
  assign w_rd    = weight_q[w_addr];
  assign trig_rd = trig_q[rd_j];
  assign w_new   = WEIGHT_W'((sum + ROUND_Q23) >>> OUT_SHIFT);

  assign trig_idx = phase_idx(sub_q[1] ? phase_b_q : phase_a_q)
                    + (sub_q[0] ? IDX_W'(QTR_DEPTH) : IDX_W'(0));

  always_comb begin
    y_full  = (PROD_W'(x_cur) <<< OUT_SHIFT) - (sum <<< 1) + ROUND_Q23;
    y_shift = y_full >>> OUT_SHIFT;
    if (y_shift > OUT_MAX) begin
      y_sat = OUT_W'(OUT_MAX);
    end else if (y_shift < OUT_MIN) begin
      y_sat = OUT_W'(OUT_MIN);
    end else begin
      y_sat = OUT_W'(y_shift);
    end
  end

  always_comb begin
    state_d         = state_q;
    sub_d           = sub_q;
    ch_d            = ch_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    mac_ctl.mul_en  = 1'b0;
    mac_ctl.acc_sel = ACC_HOLD;
    op_a            = '0;
    op_b            = '0;
    w_we            = 1'b0;
    trig_we         = 1'b0;
    phase_adv       = 1'b0;
    ea_we           = 1'b0;
    pick_we         = 1'b0;
    work_we         = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_TRIG;
          sub_d   = '0;
        end
      end
      ST_TRIG: begin
        trig_we = 1'b1;
        sub_d   = sub_q + 1'b1;
        if (sub_q[1:0] == 2'd3) begin
          phase_adv = 1'b1;
          state_d   = ST_WUPD;
          sub_d     = '0;
          ch_d      = '0;
        end
      end
      ST_WUPD: begin
        sub_d = sub_q + 1'b1;
        unique case (sub_q[1:0])
          2'd0: begin
            mac_ctl.mul_en = 1'b1;
            op_a           = w_rd;
            op_b           = OPND_W'(leak_q);
          end
          2'd1: begin
            mac_ctl.mul_en  = 1'b1;
            mac_ctl.acc_sel = ACC_PROD_SHL;
            op_a            = OPND_W'(x_cur);
            op_b            = OPND_W'(trig_rd);
          end
          2'd2: begin
            mac_ctl.mul_en = 1'b1;
            op_a           = prod[OPND_W-1:0];
            op_b           = OPND_W'(gain);
          end
          default: begin
            w_we = 1'b1;
            if (sub_q[3:2] == 2'd3) begin
              state_d = ST_ENRG;
              sub_d   = '0;
            end
          end
        endcase
      end
      ST_ENRG: begin
        sub_d = sub_q + 1'b1;
        if (sub_q == SUB_W'(4)) begin
          pick_we = 1'b1;
          state_d = ST_RECN;
          sub_d   = '0;
        end else begin
          mac_ctl.mul_en = 1'b1;
          op_a           = w_rd;
          op_b           = w_rd;
          if (sub_q[0]) begin
            mac_ctl.acc_sel = ACC_PROD;
          end
          ea_we = (sub_q == SUB_W'(2));
        end
      end
      ST_RECN: begin
        sub_d = sub_q + 1'b1;
        if (sub_q == SUB_W'(2)) begin
          work_we = 1'b1;
          sub_d   = '0;
          if (ch_q == CH_W'(NUM_CH - 1)) begin
            state_d = ST_FIN;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = ST_WUPD;
          end
        end else begin
          mac_ctl.mul_en = 1'b1;
          op_a           = w_rd;
          op_b           = OPND_W'(trig_rd);
          if (sub_q[0]) begin
            mac_ctl.acc_sel = ACC_PROD;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sub_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      phase_a_q   <= '0;
      phase_b_q   <= '0;
    end else begin
      state_q     <= state_d;
      sub_q       <= sub_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      if (phase_adv) begin
        phase_a_q <= phase_a_q + scale_step(step_a_q);
        phase_b_q <= phase_b_q + scale_step(step_b_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leak_q   <= LEAK_RESET;
      step_a_q <= STEP_A_RESET;
      step_b_q <= STEP_B_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEAK:   leak_q   <= cfg_wdata_i;
        REG_STEP_A: step_a_q <= cfg_wdata_i;
        REG_STEP_B: step_b_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH * NUM_TERMS; i++) begin
        weight_q[i] <= '0;
      end
    end else if (w_we) begin
      weight_q[w_addr] <= w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q[0] <= sample_ch0_i;
      x_q[1] <= sample_ch1_i;
      x_q[2] <= sample_ch2_i;
      x_q[3] <= sample_ch3_i;
    end
    if (trig_we) begin
      trig_q[sub_q[1:0]] <= trig_val(trig_idx);
    end
    if (ea_we) begin
      ea_q <= unsigned'(sum);
    end
    if (pick_we) begin
      pick_a_q <= ea_q > unsigned'(sum);
    end
    if (work_we) begin
      work_q[ch_q] <= y_sat;
    end
    if (out_load) begin
      for (int i = 0; i < NUM_CH; i++) begin
        clean_q[i] <= work_q[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign clean_ch0_o = clean_q[0];
  assign clean_ch1_o = clean_q[1];
  assign clean_ch2_o = clean_q[2];
  assign clean_ch3_o = clean_q[3];

endmodule

FILE: design/dtmc_checker.sv
// Port-level checks for the dual-tone mains canceller, bound to the top level.
module dtmc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [dtmc_pkg::OUT_W-1:0]    clean_ch0_o,
  input logic signed [dtmc_pkg::OUT_W-1:0]    clean_ch1_o,
  input logic signed [dtmc_pkg::OUT_W-1:0]    clean_ch2_o,
  input logic signed [dtmc_pkg::OUT_W-1:0]    clean_ch3_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("ready returned too soon after an item was taken");

  a_result_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result appeared while an item was still in work");

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(clean_ch0_o) && $stable(clean_ch1_o)
                                    && $stable(clean_ch2_o) && $stable(clean_ch3_o))
    else $error("stalled result changed");

endmodule

bind dual_tone_mains_canceller dtmc_checker u_dtmc_checker (.*);

FILE: bench/dual_tone_mains_canceller_checker.sv
`timescale 1ns / 100ps
// Checker for the dual-tone mains canceller: predicts cleaned channels and compares results.
module dual_tone_mains_canceller_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dtmc_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dtmc_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic signed [dtmc_pkg::SAMPLE_W-1:0] sample_ch0_i,
  input  logic signed [dtmc_pkg::SAMPLE_W-1:0] sample_ch1_i,
  input  logic signed [dtmc_pkg::SAMPLE_W-1:0] sample_ch2_i,
  input  logic signed [dtmc_pkg::SAMPLE_W-1:0] sample_ch3_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic signed [dtmc_pkg::OUT_W-1:0]    clean_ch0_i,
  input  logic signed [dtmc_pkg::OUT_W-1:0]    clean_ch1_i,
  input  logic signed [dtmc_pkg::OUT_W-1:0]    clean_ch2_i,
  input  logic signed [dtmc_pkg::OUT_W-1:0]    clean_ch3_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);
  import dtmc_pkg::*;

  localparam int LANES     = 4;
  localparam int ROM_DEPTH = 1024;
  localparam int PHASE_W   = 16;

  localparam logic [15:0] LEAK_INIT   = 16'd65208;
  localparam logic [15:0] STEP_A_INIT = 16'd6715;
  localparam logic [15:0] STEP_B_INIT = 16'd8058;

  localparam longint CLEAN_MAX   = 131071;
  localparam longint CLEAN_MIN   = -131072;
  localparam longint HALF_Q23    = 64'sd4194304;
  localparam logic [63:0] TAU_Q30 = 64'd6746518852;

  typedef logic [LANES-1:0][OUT_W-1:0]    clean_set_t;
  typedef logic [LANES-1:0][SAMPLE_W-1:0] sample_set_t;

  int                 sin_q15 [ROM_DEPTH];
  int                 cos_q15 [ROM_DEPTH];
  logic [15:0]        leak_q16;
  logic [15:0]        step_a_q16;
  logic [15:0]        step_b_q16;
  logic [15:0]        phase_a;
  logic [15:0]        phase_b;
  logic signed [31:0] w_sin_a [LANES];
  logic signed [31:0] w_cos_a [LANES];
  logic signed [31:0] w_sin_b [LANES];
  logic signed [31:0] w_cos_b [LANES];
  clean_set_t         expected_clean_q [$];
  int                 mismatches;

  // Q1.15 sine of a 32 bit cycle fraction, Taylor series evaluated in Q30
  function automatic int taylor_sine_q15(input logic [31:0] frac);
    logic [63:0] f;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      r;
    int          n;
    f = {33'd0, frac[30:0]};
    if (f > 64'h4000_0000) begin
      f = 64'h8000_0000 - f;
    end
    x    = (f * TAU_Q30) >> 32;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    r = (sum * 32767 + 64'sd536870912) >>> 30;
    if (r > 32767) begin
      r = 32767;
    end
    return frac[31] ? -int'(r) : int'(r);
  endfunction

  function automatic logic signed [31:0] leaky_avg(input logic signed [31:0] w,
                                                   input longint x, input longint s);
    longint acc;
    longint lk;
    lk  = leak_q16;
    acc = (longint'(w) * lk) <<< 7;
    acc = acc + x * s * (65536 - lk);
    acc = (acc + HALF_Q23) >>> 23;
    return 32'(acc);
  endfunction

  function automatic logic [63:0] tone_energy(input logic signed [31:0] s,
                                              input logic signed [31:0] c);
    longint a;
    longint b;
    a = s;
    b = c;
    return 64'(a * a) + 64'(b * b);
  endfunction

  function automatic clean_set_t cancel_mains(input sample_set_t xs);
    clean_set_t res;
    int         pa;
    int         pb;
    int         ia;
    int         ib;
    longint     sa;
    longint     ca;
    longint     sb;
    longint     cb;
    longint     x;
    longint     rec;
    longint     y;
    pa = phase_a;
    pb = phase_b;
    ia = (pa * ROM_DEPTH) >> PHASE_W;
    ib = (pb * ROM_DEPTH) >> PHASE_W;
    sa = sin_q15[ia];
    ca = cos_q15[ia];
    sb = sin_q15[ib];
    cb = cos_q15[ib];
    phase_a = phase_a + step_a_q16;
    phase_b = phase_b + step_b_q16;
    for (int c = 0; c < LANES; c++) begin
      x = signed'(xs[c]);
      w_sin_a[c] = leaky_avg(w_sin_a[c], x, sa);
      w_cos_a[c] = leaky_avg(w_cos_a[c], x, ca);
      w_sin_b[c] = leaky_avg(w_sin_b[c], x, sb);
      w_cos_b[c] = leaky_avg(w_cos_b[c], x, cb);
      if (tone_energy(w_sin_a[c], w_cos_a[c]) > tone_energy(w_sin_b[c], w_cos_b[c])) begin
        rec = longint'(w_sin_a[c]) * sa + longint'(w_cos_a[c]) * ca;
      end else begin
        rec = longint'(w_sin_b[c]) * sb + longint'(w_cos_b[c]) * cb;
      end
      y = (x <<< 23) - 2 * rec;
      y = (y + HALF_Q23) >>> 23;
      if (y > CLEAN_MAX) begin
        y = CLEAN_MAX;
      end
      if (y < CLEAN_MIN) begin
        y = CLEAN_MIN;
      end
      res[c] = OUT_W'(y);
    end
    return res;
  endfunction

  initial begin
    logic [31:0] f;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      f = 32'((64'(k) << 32) / ROM_DEPTH);
      sin_q15[k] = taylor_sine_q15(f);
      cos_q15[k] = taylor_sine_q15(f + 32'h4000_0000);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    clean_set_t got;
    clean_set_t want;
    if (!rst_ni) begin
      leak_q16   = LEAK_INIT;
      step_a_q16 = STEP_A_INIT;
      step_b_q16 = STEP_B_INIT;
      phase_a    = '0;
      phase_b    = '0;
      for (int c = 0; c < LANES; c++) begin
        w_sin_a[c] = '0;
        w_cos_a[c] = '0;
        w_sin_b[c] = '0;
        w_cos_b[c] = '0;
      end
      expected_clean_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {clean_ch3_i, clean_ch2_i, clean_ch1_i, clean_ch0_i};
        if (expected_clean_q.size() == 0) begin
          $error("clean set delivered with no item outstanding");
          mismatches++;
        end else begin
          want = expected_clean_q.pop_front();
          for (int c = 0; c < LANES; c++) begin
            if (got[c] !== want[c]) begin
              $error("clean_ch%0d: expected %0d, got %0d", c, signed'(want[c]), signed'(got[c]));
              mismatches++;
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LEAK:   leak_q16   = cfg_wdata_i;
          REG_STEP_A: step_a_q16 = cfg_wdata_i;
          REG_STEP_B: step_b_q16 = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_clean_q.push_back(cancel_mains({sample_ch3_i, sample_ch2_i,
                                                 sample_ch1_i, sample_ch0_i}));
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_clean_q.size();
    end
  end

endmodule

FILE: bench/dual_tone_mains_canceller_tb.sv
`timescale 1ns / 100ps
// Top of the dual-tone mains canceller testbench: clock, reset, stimulus and verdict.
module dual_tone_mains_canceller_tb;
  import dtmc_pkg::*;

  localparam int RANDOM_SETS   = 950;
  localparam int PHASES        = 6;
  localparam int SETTLE_CYCLES = 128;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [REG_IDX_W-1:0]       cfg_idx_i;
  logic [CFG_W-1:0]           cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_ch0_i;
  logic signed [SAMPLE_W-1:0] sample_ch1_i;
  logic signed [SAMPLE_W-1:0] sample_ch2_i;
  logic signed [SAMPLE_W-1:0] sample_ch3_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [OUT_W-1:0]    clean_ch0_o;
  logic signed [OUT_W-1:0]    clean_ch1_o;
  logic signed [OUT_W-1:0]    clean_ch2_o;
  logic signed [OUT_W-1:0]    clean_ch3_o;

  int          fail_count;
  int          pending_sets;
  bit          no_gaps;
  logic [15:0] tone_phase;
  logic [15:0] tone_step;
  int          tone_amp;
  int          tone_noise;

  dual_tone_mains_canceller dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_ch0_i (sample_ch0_i),
    .sample_ch1_i (sample_ch1_i),
    .sample_ch2_i (sample_ch2_i),
    .sample_ch3_i (sample_ch3_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .clean_ch0_o  (clean_ch0_o),
    .clean_ch1_o  (clean_ch1_o),
    .clean_ch2_o  (clean_ch2_o),
    .clean_ch3_o  (clean_ch3_o)
  );

  dual_tone_mains_canceller_checker check_clean (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .sample_ch0_i (sample_ch0_i),
    .sample_ch1_i (sample_ch1_i),
    .sample_ch2_i (sample_ch2_i),
    .sample_ch3_i (sample_ch3_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .clean_ch0_i  (clean_ch0_o),
    .clean_ch1_i  (clean_ch1_o),
    .clean_ch2_i  (clean_ch2_o),
    .clean_ch3_i  (clean_ch3_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_sets)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("dual_tone_mains_canceller_tb NOT OK");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 4);
    end
    if (r < 98) begin
      return $urandom_range(5, 24);
    end
    return $urandom_range(60, 300);
  endfunction

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // triangle-shaped mains tone with noise, offset by a quarter cycle per lane
  function automatic logic [15:0] mains_sample(input int lane);
    int p;
    int tri_v;
    int noise;
    int v;
    p     = tone_phase;
    p     = (p + lane * 16384) & 16'hFFFF;
    tri_v = (p < 32768) ? (p - 16384) : (49151 - p);
    noise = $urandom_range(2 * tone_noise);
    v     = (tri_v * tone_amp) / 8 + noise - tone_noise;
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return 16'(v);
  endfunction

  task automatic send_set(input logic [15:0] s0, input logic [15:0] s1,
                          input logic [15:0] s2, input logic [15:0] s3);
    int gap;
    gap = no_gaps ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_ch0_i <= s0;
    sample_ch1_i <= s1;
    sample_ch2_i <= s2;
    sample_ch3_i <= s3;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    do @(posedge clk_i); while (pending_sets != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] leak, input logic [15:0] step_a,
                           input logic [15:0] step_b);
    in_valid_i <= 1'b0;
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_LEAK;
    cfg_wdata_i <= leak;
    @(posedge clk_i);
    cfg_idx_i   <= REG_STEP_A;
    cfg_wdata_i <= step_a;
    @(posedge clk_i);
    cfg_idx_i   <= REG_STEP_B;
    cfg_wdata_i <= step_b;
    @(posedge clk_i);
    cfg_idx_i   <= REG_SPARE;
    cfg_wdata_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_set();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      send_set(mains_sample(0), mains_sample(1), mains_sample(2), mains_sample(3));
      tone_phase = tone_phase + tone_step;
    end else if (r < 90) begin
      send_set(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      send_set(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
    end
  endtask

  initial begin
    int burst;
    int stall;
    out_ready_i = 1'b0;
    forever begin
      burst = ($urandom_range(7) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 12);
      repeat (burst) @(posedge clk_i) out_ready_i <= 1'b1;
      stall = idle_len();
      repeat (stall) @(posedge clk_i) out_ready_i <= 1'b0;
    end
  end

  initial begin
    logic [15:0] leak;
    logic [15:0] step_a;
    logic [15:0] step_b;
    int          per_phase;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_LEAK;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    sample_ch0_i = '0;
    sample_ch1_i = '0;
    sample_ch2_i = '0;
    sample_ch3_i = '0;
    no_gaps      = 1'b0;
    tone_phase   = '0;
    tone_step    = '0;
    tone_amp     = 8;
    tone_noise   = 0;
    per_phase    = (RANDOM_SETS + PHASES - 1) / PHASES;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // equal energies on the first set, then field extremes under the reset settings
    send_set(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_set(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
    send_set(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
    send_set(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_set(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_set(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_set(16'h8000, 16'h8000, 16'h8000, 16'h8000);

    // zero leak: weights follow the instantaneous product
    configure(16'h0000, 16'h0000, 16'hFFFF);
    send_set(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_set(16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF);
    send_set(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    repeat (3) send_set(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());

    // maximum retention with opposite step extremes
    configure(16'hFFFF, 16'hFFFF, 16'h0000);
    send_set(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_set(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_set(16'hFFFF, 16'h0001, 16'h0000, 16'h7FFF);
    repeat (3) send_set(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          leak   = 16'd65208;
          step_a = 16'd6715;
          step_b = 16'd8058;
        end
        PHASES - 1: begin
          leak   = 16'hFFFF;
          step_a = 16'h0000;
          step_b = 16'($urandom_range(1, 65535));
        end
        default: begin
          leak   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(60000, 65535));
          step_a = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(1000, 12000));
          step_b = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(1000, 12000));
        end
      endcase
      configure(leak, step_a, step_b);
      no_gaps    = ($urandom_range(3) == 0);
      tone_noise = $urandom_range(0, 2000);
      for (int i = 0; i < per_phase; i++) begin
        if (i % 40 == 0) begin
          tone_step = $urandom_range(1) ? step_a : step_b;
          tone_amp  = $urandom_range(1, 16);
        end
        random_set();
      end
    end

    in_valid_i <= 1'b0;
    drain();
    if (fail_count == 0 && pending_sets == 0) begin
      $display("dual_tone_mains_canceller_tb OK");
    end else begin
      $display("dual_tone_mains_canceller_tb NOT OK");
    end
    $finish;
  end

endmodule
